>>> design/shapad_pkg.sv
// ----------------------------------------------------------------------------
// SHA-256 message padder package
// Shared types and constants for the padder controller and datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package shapad_pkg;

  // Byte appended right after the last message byte.
  localparam logic [7:0] PAD_MARK = 8'h80;

  // Word positions inside a 512-bit block.
  localparam logic [3:0] LEN_HI_WORD = 4'd14;
  localparam logic [3:0] LAST_WORD   = 4'd15;

  // Message length grows by one byte, that is eight bits.
  localparam logic [63:0] BITS_PER_BYTE = 64'd8;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_PAD  = 2'b10
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic byte_load;  // pack a message byte
    logic pad_load;   // emit the word holding the 0x80 marker
    logic fill_load;  // emit a zero or length word
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;   // output register can take a word this cycle
    logic fill_last;  // next fill word is the final word of the message
  } status_t;

endpackage

`default_nettype wire

>>> design/shapad_datapath.sv
// ----------------------------------------------------------------------------
// SHA-256 padder datapath
// Packs bytes into words, builds padding and length words, holds the output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module shapad_datapath (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire shapad_pkg::cmd_t  cmd_i,
  output shapad_pkg::status_t    status_o,
  input  wire logic [7:0]        data_byte_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [31:0]            block_word_o,
  output logic [3:0]             word_index_o,
  output logic                   block_last_o,
  output logic                   message_last_o
);
  import shapad_pkg::*;

  logic [23:0] partial_q, partial_d;
  logic [5:0]  pos_q, pos_d;
  logic [63:0] total_bits_q, total_bits_d;
  logic [3:0]  cnt_q, cnt_d;
  logic        wrap_q, wrap_d;

  logic        out_valid_q, out_valid_d;
  logic [31:0] word_q, word_d;
  logic [3:0]  index_q, index_d;
  logic        blast_q, blast_d;
  logic        mlast_q, mlast_d;

  logic [31:0] packed_word;
  logic [31:0] pad_word;
  logic [31:0] fill_word;
  logic        fill_last;

  assign packed_word = {partial_q, data_byte_i};
  assign fill_last   = !wrap_q && (cnt_q == LAST_WORD);

  // Remaining message bytes move to the top, followed by the marker.
  always_comb begin
    unique case (pos_q[1:0])
      2'd0:    pad_word = {PAD_MARK, 24'h000000};
      2'd1:    pad_word = {partial_q[7:0], PAD_MARK, 16'h0000};
      2'd2:    pad_word = {partial_q[15:0], PAD_MARK, 8'h00};
      2'd3:    pad_word = {partial_q[23:0], PAD_MARK};
      default: pad_word = 32'h00000000;
    endcase
  end

  // Length goes out most significant word first in the last two slots.
  always_comb begin
    if (!wrap_q && cnt_q == LEN_HI_WORD) begin
      fill_word = total_bits_q[63:32];
    end else if (fill_last) begin
      fill_word = total_bits_q[31:0];
    end else begin
      fill_word = 32'h00000000;
    end
  end

  always_comb begin
    partial_d    = partial_q;
    pos_d        = pos_q;
    total_bits_d = total_bits_q;
    cnt_d        = cnt_q;
    wrap_d       = wrap_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    word_d       = word_q;
    index_d      = index_q;
    blast_d      = blast_q;
    mlast_d      = mlast_q;

    if (cmd_i.byte_load) begin
      pos_d        = pos_q + 6'd1;
      total_bits_d = total_bits_q + BITS_PER_BYTE;
      if (pos_q[1:0] == 2'd3) begin
        partial_d   = 24'h000000;
        out_valid_d = 1'b1;
        word_d      = packed_word;
        index_d     = pos_q[5:2];
        blast_d     = (pos_q[5:2] == LAST_WORD);
        mlast_d     = 1'b0;
      end else begin
        partial_d = packed_word[23:0];
      end
    end

    if (cmd_i.pad_load) begin
      out_valid_d = 1'b1;
      word_d      = pad_word;
      index_d     = pos_q[5:2];
      blast_d     = (pos_q[5:2] == LAST_WORD);
      mlast_d     = 1'b0;
      cnt_d       = pos_q[5:2] + 4'd1;
      // A marker in word 14 leaves no room for the length in this block.
      wrap_d      = (pos_q[5:2] == LEN_HI_WORD);
    end

    if (cmd_i.fill_load) begin
      out_valid_d = 1'b1;
      word_d      = fill_word;
      index_d     = cnt_q;
      blast_d     = (cnt_q == LAST_WORD);
      mlast_d     = fill_last;
      cnt_d       = cnt_q + 4'd1;
      if (cnt_q == LAST_WORD) begin
        wrap_d = 1'b0;
      end
      if (fill_last) begin
        partial_d    = 24'h000000;
        pos_d        = 6'd0;
        total_bits_d = 64'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      partial_q    <= 24'h000000;
      pos_q        <= 6'd0;
      total_bits_q <= 64'd0;
      cnt_q        <= 4'd0;
      wrap_q       <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      partial_q    <= partial_d;
      pos_q        <= pos_d;
      total_bits_q <= total_bits_d;
      cnt_q        <= cnt_d;
      wrap_q       <= wrap_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q  <= word_d;
    index_q <= index_d;
    blast_q <= blast_d;
    mlast_q <= mlast_d;
  end

  assign status_o.out_free  = !out_valid_q || out_ready_i;
  assign status_o.fill_last = fill_last;

  assign out_valid_o    = out_valid_q;
  assign block_word_o   = word_q;
  assign word_index_o   = index_q;
  assign block_last_o   = blast_q;
  assign message_last_o = mlast_q;

  // The spill flag is only ever set while word 15 of the first block is due.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    wrap_q |-> (cnt_q == LAST_WORD))
    else $error("spill flag set away from word 15");

  // After the final word all message state is back at its reset value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.fill_load && fill_last) |=> (pos_q == 6'd0 && total_bits_q == 64'd0))
    else $error("message state not cleared after final word");

endmodule

`default_nettype wire

>>> design/shapad_ctrl.sv
// ----------------------------------------------------------------------------
// SHA-256 padder controller
// Takes requests and sequences the padding words through the datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module shapad_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic                 is_end_i,
  input  wire shapad_pkg::status_t  status_i,
  output shapad_pkg::cmd_t          cmd_o
);
  import shapad_pkg::*;

  state_e state_q, state_d;
  logic   accept;

  assign in_ready_o = (state_q == ST_IDLE) && status_i.out_free;
  assign accept     = in_valid_i && in_ready_o;

  assign cmd_o.byte_load = accept && !is_end_i;
  assign cmd_o.pad_load  = accept && is_end_i;
  assign cmd_o.fill_load = (state_q == ST_PAD) && status_i.out_free;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_o.pad_load) begin
          state_d = ST_PAD;
        end
      end
      ST_PAD: begin
        if (cmd_o.fill_load && status_i.fill_last) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // No request is taken while padding words are still being produced.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PAD) |-> !in_ready_o)
    else $error("request taken during padding");

  // An end marker always starts the padding sequence.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.pad_load |=> (state_q == ST_PAD))
    else $error("end marker did not start padding");

endmodule

`default_nettype wire

>>> design/sha256_message_padder_core.sv
// ----------------------------------------------------------------------------
// SHA-256 message padder
// Packs a byte stream into big-endian words and appends SHA-256 padding.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake              Payload
//   -------  ---------  ---------------------  -----------------------------------
//   in       input      in_valid_i/in_ready_o  data_byte_i, is_end_i
//   out      output     out_valid_o/out_ready_i block_word_o, word_index_o,
//                                              block_last_o, message_last_o
//
// Message bytes stream in at one per cycle while the output register is free;
// every fourth byte places a finished word in the single output register.
// An end marker is taken like a message byte and then holds the input side
// while the remaining padding words (2 to 17) are issued, since all words leave
// through that one output register. Output stalls stretch this hold.
// Reset clears the packed bytes, block position and bit count immediately;
// the same state is cleared again as the final word of each message is loaded.
//
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sha256_message_padder_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        is_end_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [31:0]      block_word_o,
  output logic [3:0]       word_index_o,
  output logic             block_last_o,
  output logic             message_last_o
);
  import shapad_pkg::*;

  cmd_t    cmd;
  status_t status;

  // The controller decides when a request is taken and when each padding
  // word is issued; it only proceeds when the output register is free.
  shapad_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .is_end_i   (is_end_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // The datapath holds the partial word, the byte position in the block,
  // the running bit length and the output register.
  shapad_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .data_byte_i    (data_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .block_word_o   (block_word_o),
    .word_index_o   (word_index_o),
    .block_last_o   (block_last_o),
    .message_last_o (message_last_o)
  );

endmodule

`default_nettype wire

>>> tb/sv/sha256_message_padder_core_tb.sv
// ----------------------------------------------------------------------------
// SHA-256 message padder testbench
// Streams byte messages with end markers into the padder and checks every
// emitted word against a cycle-free prediction of the padded message. Runs
// fixed edge-case messages, random messages under several idle and stall
// mixes, and a long output hold-off that backs up the input side.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sha256_message_padder_core_tb;

  import shapad_pkg::*;

  // Byte position inside a block where the 64-bit length field starts.
  localparam logic [5:0] LEN_BYTE_POS = 6'd56;
  localparam int         CYCLE_LIMIT  = 60000;
  localparam int         DRAIN_CYCLES = 40;
  localparam int         HOLD_CYCLES  = 200;
  localparam int         MAX_REPORTS  = 10;

  // One word of the padded message as it leaves the block.
  typedef struct packed {
    logic [31:0] word;
    logic [3:0]  index;
    logic        blk_last;
    logic        msg_last;
  } padded_word_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  data_byte_i;
  logic        is_end_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [31:0] block_word_o;
  logic [3:0]  word_index_o;
  logic        block_last_o;
  logic        message_last_o;

  // Predictor state: bytes of the unfinished word, position in the block and
  // the running message length in bits.
  logic [23:0] pend_word;
  logic [5:0]  blk_pos;
  logic [63:0] msg_bits;

  // Words the block still owes us, oldest first.
  padded_word_t padded_words_q[$];

  int err_cnt;
  int cycle_cnt;
  int gap_pct;     // chance in percent that the sender idles a cycle
  int stall_pct;   // chance in percent that the receiver stalls a cycle
  logic hold_off;  // forces the receiver to stall while set

  sha256_message_padder_core i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .data_byte_i    (data_byte_i),
    .is_end_i       (is_end_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .block_word_o   (block_word_o),
    .word_index_o   (word_index_o),
    .block_last_o   (block_last_o),
    .message_last_o (message_last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Padding predictor
  // --------------------------------------------------------------------------

  // Shift one byte into the current word. The fourth byte of a word finishes
  // it, and the word is queued with its place in the 512-bit block.
  function automatic void pack_byte(input logic [7:0] b, input logic last);
    logic [31:0]  word;
    padded_word_t w;
    word = {pend_word, b};
    if (blk_pos[1:0] == 2'd3) begin
      w.word     = word;
      w.index    = blk_pos[5:2];
      w.blk_last = (blk_pos == 6'd63);
      w.msg_last = last;
      padded_words_q.push_back(w);
      pend_word = '0;
    end else begin
      pend_word = word[23:0];
    end
    blk_pos = blk_pos + 6'd1;
  endfunction

  // A message byte only packs. An end marker appends the 0x80 mark, zero
  // bytes up to the length field (running into a second block when the mark
  // lands past it) and the bit length, most significant byte first. The
  // data byte that comes with an end marker plays no part.
  function automatic void predict_padding(input logic [7:0] b, input logic last_req);
    if (!last_req) begin
      pack_byte(b, 1'b0);
      msg_bits = msg_bits + BITS_PER_BYTE;
    end else begin
      pack_byte(PAD_MARK, 1'b0);
      while (blk_pos != LEN_BYTE_POS) pack_byte(8'h00, 1'b0);
      for (int i = 7; i >= 0; i--) pack_byte(msg_bits[8*i +: 8], i == 0);
      pend_word = '0;
      blk_pos   = '0;
      msg_bits  = '0;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Scoreboard: predicts from each accepted request and checks each accepted
  // word in the same process, so a word and its prediction never race.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : check_words
    padded_word_t got;
    padded_word_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) predict_padding(data_byte_i, is_end_i);
      if (out_valid_o && out_ready_i) begin
        got = {block_word_o, word_index_o, block_last_o, message_last_o};
        if (padded_words_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= MAX_REPORTS)
            $display("%0t: unexpected word %h index %0d block_last %b message_last %b",
                     $realtime, got.word, got.index, got.blk_last, got.msg_last);
        end else begin
          want = padded_words_q.pop_front();
          if (got !== want) begin
            err_cnt++;
            if (err_cnt <= MAX_REPORTS)
              $display("%0t: word mismatch: expected %h/%0d/%b/%b, got %h/%0d/%b/%b",
                       $realtime, want.word, want.index, want.blk_last, want.msg_last,
                       got.word, got.index, got.blk_last, got.msg_last);
          end
        end
      end
    end
  end

  // Receiver: stalls at random, or without a break while a hold-off runs.
  always @(posedge clk_i) begin
    out_ready_i <= !hold_off && ($urandom_range(99) >= stall_pct);
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------

  // Offer one request after a random number of idle cycles and return right
  // after the edge that accepts it. Called and returning on a rising edge.
  task automatic send_request(input logic [7:0] b, input logic last_req);
    while ($urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    is_end_i    <= last_req;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // A message of random bytes closed by an end marker with a random byte.
  task automatic send_message(input int len);
    for (int k = 0; k < len; k++) send_request(8'($urandom_range(255)), 1'b0);
    send_request(8'($urandom_range(255)), 1'b1);
  endtask

  // Drop valid so a finished test never offers a stale request.
  task automatic go_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Empty message, with all-ones data on the end marker that must be ignored,
  // then short messages with byte extremes, the pad byte value as data and a
  // message that ends exactly on a word boundary.
  task automatic test_edge_messages();
    gap_pct    = 0;
    stall_pct <= 0;
    send_request(8'hFF, 1'b1);
    send_request(8'hFF, 1'b0);
    send_request(8'h00, 1'b1);
    send_request(8'h00, 1'b0);
    send_request(8'hFF, 1'b0);
    send_request(PAD_MARK, 1'b0);
    send_request(8'h00, 1'b1);
    send_request(8'h61, 1'b0);
    send_request(8'h62, 1'b0);
    send_request(8'h63, 1'b0);
    send_request(8'h64, 1'b0);
    send_request(8'h5A, 1'b1);
    go_idle();
  endtask

  // Random messages, mostly short, a fifth of them near or past one block
  // so that spills into an extra block and full blocks of data come up.
  task automatic test_random_messages(input int gap, input int stall, input int budget);
    int sent;
    int len;
    gap_pct    = gap;
    stall_pct <= stall;
    sent       = 0;
    while (sent < budget) begin
      if ($urandom_range(99) < 80) len = $urandom_range(11);
      else                         len = $urandom_range(66, 52);
      send_message(len);
      sent += len + 1;
    end
    go_idle();
  endtask

  // The receiver stops for a long stretch while the sender keeps offering a
  // message that just fits one block and one that just spills, so the single
  // output register fills and the input side has to back up.
  task automatic test_output_hold_off();
    gap_pct    = 0;
    stall_pct <= 0;
    fork
      begin
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_off <= 1'b0;
      end
      begin
        send_message(55);
        send_message(56);
        go_idle();
      end
    join
  endtask

  initial begin
    err_cnt      = 0;
    cycle_cnt   <= 0;
    gap_pct      = 0;
    stall_pct   <= 0;
    hold_off    <= 1'b0;
    pend_word    = '0;
    blk_pos      = '0;
    msg_bits     = '0;
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    data_byte_i <= 8'h00;
    is_end_i    <= 1'b0;
    out_ready_i <= 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_edge_messages();
    test_random_messages(0, 0, 5);
    test_random_messages(60, 0, 5);
    test_random_messages(0, 60, 5);
    test_random_messages(17, 17, 5);
    test_output_hold_off();

    // Let the last padding words leave, then watch for stray words.
    while (padded_words_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
